// ===== src/quad_bowtie_detect_fix_macros.svh =====
// assertion macros for the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef QUAD_BOWTIE_DETECT_FIX_MACROS_SVH
`define QUAD_BOWTIE_DETECT_FIX_MACROS_SVH

// clocked assertion, off while reset is active
`define QBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion, also checked during reset
`define QBD_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/qbd_pkg.sv =====
`default_nettype none

package qbd_pkg;

    // vertex codes used in the slot fields
    typedef enum logic [1:0]
    {
        SRC_A = 2'd0,
        SRC_B = 2'd1,
        SRC_C = 2'd2,
        SRC_D = 2'd3
    } vertex_src_t;

    localparam int NUM_VERT  = 4;
    localparam int NUM_AXIS  = 3;
    localparam int NUM_EDGE  = 6;
    localparam int NUM_CROSS = 8;
    localparam int NUM_DOT   = 4;

    // edges: ab, ac, ad, cd, ca, cb as head minus tail
    localparam int EDGE_HEAD [NUM_EDGE] = '{1, 2, 3, 3, 0, 1};
    localparam int EDGE_TAIL [NUM_EDGE] = '{0, 0, 0, 2, 2, 2};

    // cross products u x v by edge index; dot k pairs cross 2k and 2k+1
    // ad x ab, ad x ac, cb x ca, cb x cd, ab x ac, ab x ad, cd x ca, cd x cb
    localparam int CROSS_U [NUM_CROSS] = '{2, 2, 5, 5, 0, 0, 3, 3};
    localparam int CROSS_V [NUM_CROSS] = '{0, 1, 4, 3, 1, 2, 4, 5};

    // cyclic axis neighbors for the cross product terms
    localparam int AXIS_NEXT [NUM_AXIS] = '{1, 2, 0};
    localparam int AXIS_PREV [NUM_AXIS] = '{2, 0, 1};

endpackage

`default_nettype wire

// ===== src/qbd_if.sv =====
`default_nettype none

// quad item channel
interface qbd_quad_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] dx;
    logic signed [COORD_WIDTH-1:0] dy;
    logic signed [COORD_WIDTH-1:0] dz;

    modport source
    (
        output valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
        input  ready
    );

    modport sink
    (
        input  valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
        output ready
    );
endinterface

// result item channel
interface qbd_result_if;
    logic       valid;
    logic       ready;
    logic       cross_first;
    logic       cross_second;
    logic [1:0] slot0_source;
    logic [1:0] slot1_source;
    logic [1:0] slot2_source;
    logic [1:0] slot3_source;

    modport source
    (
        output valid, cross_first, cross_second,
               slot0_source, slot1_source, slot2_source, slot3_source,
        input  ready
    );

    modport sink
    (
        input  valid, cross_first, cross_second,
               slot0_source, slot1_source, slot2_source, slot3_source,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/quad_bowtie_detect_fix.sv =====
// Bowtie detector and vertex order fix for one 3-D quad per item.
// Input channel quad: vertices A, B, C, D as signed fixed point coordinates.
// Output channel result: two crossing flags (edges BC/DA, edges AB/CD) and
// the source vertex for each of the four output slots.
// cfg_we/cfg_wdata write the correct_bowtie bit; with it set, a first-test
// crossing swaps C and D, otherwise a second-test crossing swaps B and C.
// Throughput: one quad per cycle while the receiver takes results, set by
// the seven-stage pipeline (edges, cross multiplies, cross sums, split dot
// multiplies, dot terms, dot sums, output register) with every stage
// loading each cycle.
// Each stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and a quad is taken while a
// finished result still waits on the output.
// When the receiver stalls, the output holds its result and the stages
// fill up behind it; quad.ready drops only once all seven are full.
// Reset clears all valid bits and correct_bowtie; no result is pending.
`default_nettype none

module quad_bowtie_detect_fix #(
    parameter int COORD_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    qbd_quad_if.sink           quad,
    qbd_result_if.source       result
);

    localparam int W         = COORD_WIDTH;
    localparam int DW        = W + 1;           // edge component
    localparam int PW        = 2 * DW;          // cross product term
    localparam int CW        = PW + 1;          // cross product component
    localparam int LO        = (CW + 1) / 2;    // low split of a cross component
    localparam int HI        = CW - LO;         // high split
    localparam int HH        = 2 * HI;
    localparam int HL        = HI + LO + 1;
    localparam int LL        = 2 * LO;
    localparam int TW        = 2 * CW;          // dot term
    localparam int SW        = TW + 2;          // dot sum
    localparam int NUM_STAGE = 7;

    localparam int NV = qbd_pkg::NUM_VERT;
    localparam int NA = qbd_pkg::NUM_AXIS;
    localparam int NE = qbd_pkg::NUM_EDGE;
    localparam int NX = qbd_pkg::NUM_CROSS;
    localparam int ND = qbd_pkg::NUM_DOT;

    logic [NUM_STAGE-1:0] vld_reg;
    logic [NUM_STAGE-1:0] rdy;
    logic                 cfg_correct_reg;

    logic signed [W-1:0]  vert [NV][NA];

    logic signed [DW-1:0] edge_reg [NE][NA];
    logic signed [PW-1:0] prod_reg [NX][NA][2];
    logic signed [CW-1:0] crs_reg  [NX][NA];
    logic signed [HH-1:0] hh_reg   [ND][NA];
    logic signed [HL-1:0] hl_reg   [ND][NA];
    logic signed [HL-1:0] lh_reg   [ND][NA];
    logic        [LL-1:0] ll_reg   [ND][NA];
    logic signed [TW-1:0] term_reg [ND][NA];
    logic        [ND-1:0] neg_reg;

    logic signed [HH-1:0] hh_next  [ND][NA];
    logic signed [HL-1:0] hl_next  [ND][NA];
    logic signed [HL-1:0] lh_next  [ND][NA];
    logic        [LL-1:0] ll_next  [ND][NA];
    logic signed [SW-1:0] sum_next [ND];
    logic        [ND-1:0] neg_next;

    logic                 cross_first_reg;
    logic                 cross_second_reg;
    logic                 cross_first_next;
    logic                 cross_second_next;
    qbd_pkg::vertex_src_t slot_reg  [NV];
    qbd_pkg::vertex_src_t slot_next [NV];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_correct_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            cfg_correct_reg <= cfg_wdata;
        end
    end

    // stage ready chain: a stage loads when empty or when the next one moves
    always_comb
    begin
        rdy[NUM_STAGE-1] = !vld_reg[NUM_STAGE-1] || result.ready;
        for (int i = NUM_STAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= quad.valid;
            end
            for (int i = 1; i < NUM_STAGE; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // vertex array from the input fields
    always_comb
    begin
        vert[0][0] = quad.ax;
        vert[0][1] = quad.ay;
        vert[0][2] = quad.az;
        vert[1][0] = quad.bx;
        vert[1][1] = quad.by;
        vert[1][2] = quad.bz;
        vert[2][0] = quad.cx;
        vert[2][1] = quad.cy;
        vert[2][2] = quad.cz;
        vert[3][0] = quad.dx;
        vert[3][1] = quad.dy;
        vert[3][2] = quad.dz;
    end

    // stage 0: edge vectors
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int e = 0; e < NE; e++)
            begin
                for (int c = 0; c < NA; c++)
                begin
                    edge_reg[e][c] <= DW'(vert[qbd_pkg::EDGE_HEAD[e]][c])
                                    - DW'(vert[qbd_pkg::EDGE_TAIL[e]][c]);
                end
            end
        end
    end

    // stage 1: the two products of each cross component
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int x = 0; x < NX; x++)
            begin
                for (int c = 0; c < NA; c++)
                begin
                    prod_reg[x][c][0] <=
                        PW'(edge_reg[qbd_pkg::CROSS_U[x]][qbd_pkg::AXIS_NEXT[c]])
                      * PW'(edge_reg[qbd_pkg::CROSS_V[x]][qbd_pkg::AXIS_PREV[c]]);
                    prod_reg[x][c][1] <=
                        PW'(edge_reg[qbd_pkg::CROSS_U[x]][qbd_pkg::AXIS_PREV[c]])
                      * PW'(edge_reg[qbd_pkg::CROSS_V[x]][qbd_pkg::AXIS_NEXT[c]]);
                end
            end
        end
    end

    // stage 2: cross components
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int x = 0; x < NX; x++)
            begin
                for (int c = 0; c < NA; c++)
                begin
                    crs_reg[x][c] <= CW'(prod_reg[x][c][0]) - CW'(prod_reg[x][c][1]);
                end
            end
        end
    end

    // stage 3: dot products split into high and low partial products
    always_comb
    begin
        for (int k = 0; k < ND; k++)
        begin
            for (int c = 0; c < NA; c++)
            begin
                hh_next[k][c] = HH'($signed(crs_reg[2*k][c][CW-1:LO]))
                              * HH'($signed(crs_reg[2*k+1][c][CW-1:LO]));
                hl_next[k][c] = HL'($signed(crs_reg[2*k][c][CW-1:LO]))
                              * HL'($signed({1'b0, crs_reg[2*k+1][c][LO-1:0]}));
                lh_next[k][c] = HL'($signed({1'b0, crs_reg[2*k][c][LO-1:0]}))
                              * HL'($signed(crs_reg[2*k+1][c][CW-1:LO]));
                ll_next[k][c] = LL'(crs_reg[2*k][c][LO-1:0])
                              * LL'(crs_reg[2*k+1][c][LO-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
    end

    // stage 4: recombine partial products into full dot terms
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int k = 0; k < ND; k++)
            begin
                for (int c = 0; c < NA; c++)
                begin
                    term_reg[k][c] <= (TW'(hh_reg[k][c]) <<< LL)
                                    + (TW'(hl_reg[k][c]) <<< LO)
                                    + (TW'(lh_reg[k][c]) <<< LO)
                                    + TW'($signed({1'b0, ll_reg[k][c]}));
                end
            end
        end
    end

    // stage 5: dot sums and their signs
    always_comb
    begin
        for (int k = 0; k < ND; k++)
        begin
            sum_next[k] = SW'(term_reg[k][0]) + SW'(term_reg[k][1])
                        + SW'(term_reg[k][2]);
            neg_next[k] = sum_next[k][SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            neg_reg <= neg_next;
        end
    end

    // stage 6: crossing flags and repaired vertex order
    always_comb
    begin
        cross_first_next  = neg_reg[0] && neg_reg[1];
        cross_second_next = neg_reg[2] && neg_reg[3];
        slot_next[0] = qbd_pkg::SRC_A;
        slot_next[1] = qbd_pkg::SRC_B;
        slot_next[2] = qbd_pkg::SRC_C;
        slot_next[3] = qbd_pkg::SRC_D;
        if (cfg_correct_reg)
        begin
            if (cross_first_next)
            begin
                slot_next[2] = qbd_pkg::SRC_D;
                slot_next[3] = qbd_pkg::SRC_C;
            end
            else if (cross_second_next)
            begin
                slot_next[1] = qbd_pkg::SRC_C;
                slot_next[2] = qbd_pkg::SRC_B;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            cross_first_reg  <= cross_first_next;
            cross_second_reg <= cross_second_next;
            slot_reg         <= slot_next;
        end
    end

    // channel outputs
    assign quad.ready           = rdy[0];
    assign result.valid         = vld_reg[NUM_STAGE-1];
    assign result.cross_first   = cross_first_reg;
    assign result.cross_second  = cross_second_reg;
    assign result.slot0_source  = slot_reg[0];
    assign result.slot1_source  = slot_reg[1];
    assign result.slot2_source  = slot_reg[2];
    assign result.slot3_source  = slot_reg[3];

endmodule

`default_nettype wire

// ===== src/qbd_checker.sv =====
`default_nettype none
`include "quad_bowtie_detect_fix_macros.svh"

module qbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       cross_first,
    input logic       cross_second,
    input logic [1:0] slot0,
    input logic [1:0] slot1,
    input logic [1:0] slot2,
    input logic [1:0] slot3
);

    // no result item shows while reset is held
    `QBD_ASSERT_ANY(a_reset_idle, (!rst_n |-> !res_valid), "result valid during reset")

    // a stalled result item holds
    `QBD_ASSERT(a_res_hold, (res_valid && !res_ready |=> res_valid && $stable({cross_first, cross_second, slot0, slot1, slot2, slot3})), "stalled result changed")

    // no crossing keeps the input order
    `QBD_ASSERT(a_order_plain, (res_valid && !cross_first && !cross_second |-> slot0 == qbd_pkg::SRC_A && slot1 == qbd_pkg::SRC_B && slot2 == qbd_pkg::SRC_C && slot3 == qbd_pkg::SRC_D), "order changed without a crossing")

    // first crossing may only exchange C and D
    `QBD_ASSERT(a_order_first, (res_valid && cross_first |-> slot0 == qbd_pkg::SRC_A && slot1 == qbd_pkg::SRC_B && ((slot2 == qbd_pkg::SRC_C && slot3 == qbd_pkg::SRC_D) || (slot2 == qbd_pkg::SRC_D && slot3 == qbd_pkg::SRC_C))), "bad order on first crossing")

    // second crossing alone may only exchange B and C
    `QBD_ASSERT(a_order_second, (res_valid && !cross_first && cross_second |-> slot0 == qbd_pkg::SRC_A && slot3 == qbd_pkg::SRC_D && ((slot1 == qbd_pkg::SRC_B && slot2 == qbd_pkg::SRC_C) || (slot1 == qbd_pkg::SRC_C && slot2 == qbd_pkg::SRC_B))), "bad order on second crossing")

endmodule

bind quad_bowtie_detect_fix qbd_checker u_qbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .cross_first  (result.cross_first),
    .cross_second (result.cross_second),
    .slot0        (result.slot0_source),
    .slot1        (result.slot1_source),
    .slot2        (result.slot2_source),
    .slot3        (result.slot3_source)
);

`default_nettype wire

// ===== tb/sv/quad_bowtie_detect_fix_test.sv =====
`timescale 1ns / 1ps

module quad_bowtie_detect_fix_test;

    localparam int COORD_W = 16;
    localparam int U       = 16;    // one unit in 1/16 fixed point
    localparam int EXTREMES [5] = '{-32768, -1, 0, 1, 32767};

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed
    {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed
    {
        vertex_t a;
        vertex_t b;
        vertex_t c;
        vertex_t d;
    } quad_t;

    typedef struct packed
    {
        logic                 cross_first;
        logic                 cross_second;
        qbd_pkg::vertex_src_t slot0;
        qbd_pkg::vertex_src_t slot1;
        qbd_pkg::vertex_src_t slot2;
        qbd_pkg::vertex_src_t slot3;
    } order_result_t;

    // exact integer vector used by the predictor
    typedef struct
    {
        longint x;
        longint y;
        longint z;
    } lvec_t;

    // one row of the directed table
    typedef struct
    {
        bit            fix;
        bit            typed;
        quad_t         q;
        order_result_t want;
    } probe_t;

    localparam order_result_t NO_CROSS =
        '{cross_first: 1'b0, cross_second: 1'b0,
          slot0: qbd_pkg::SRC_A, slot1: qbd_pkg::SRC_B,
          slot2: qbd_pkg::SRC_C, slot3: qbd_pkg::SRC_D};
    localparam order_result_t FIRST_KEEP =
        '{cross_first: 1'b1, cross_second: 1'b0,
          slot0: qbd_pkg::SRC_A, slot1: qbd_pkg::SRC_B,
          slot2: qbd_pkg::SRC_C, slot3: qbd_pkg::SRC_D};
    localparam order_result_t SECOND_KEEP =
        '{cross_first: 1'b0, cross_second: 1'b1,
          slot0: qbd_pkg::SRC_A, slot1: qbd_pkg::SRC_B,
          slot2: qbd_pkg::SRC_C, slot3: qbd_pkg::SRC_D};
    localparam order_result_t FIRST_FIX =
        '{cross_first: 1'b1, cross_second: 1'b0,
          slot0: qbd_pkg::SRC_A, slot1: qbd_pkg::SRC_B,
          slot2: qbd_pkg::SRC_D, slot3: qbd_pkg::SRC_C};
    localparam order_result_t SECOND_FIX =
        '{cross_first: 1'b0, cross_second: 1'b1,
          slot0: qbd_pkg::SRC_A, slot1: qbd_pkg::SRC_C,
          slot2: qbd_pkg::SRC_B, slot3: qbd_pkg::SRC_D};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    qbd_quad_if #(.COORD_WIDTH(COORD_W)) quad_ch ();
    qbd_result_if                        result_ch ();

    order_result_t pending_orders [$];
    probe_t        probes [$];
    bit            correction_on = 1'b0;
    bit            send_burst    = 1'b0;
    bit            take_burst    = 1'b0;
    int            mismatch_count = 0;

    quad_bowtie_detect_fix #(.COORD_WIDTH(COORD_W)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .quad      (quad_ch),
        .result    (result_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("quad_bowtie_detect_fix_test: FAIL");
        $finish;
    end

    function automatic vertex_t vtx(int x, int y, int z);
        vertex_t p;
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        p.z = coord_t'(z);
        return p;
    endfunction

    function automatic lvec_t widen(vertex_t p);
        lvec_t r;
        r.x = p.x;
        r.y = p.y;
        r.z = p.z;
        return r;
    endfunction

    function automatic lvec_t span(lvec_t head, lvec_t tail);
        lvec_t r;
        r.x = head.x - tail.x;
        r.y = head.y - tail.y;
        r.z = head.z - tail.z;
        return r;
    endfunction

    function automatic lvec_t cross_of(lvec_t u, lvec_t v);
        lvec_t r;
        r.x = u.y * v.z - u.z * v.y;
        r.y = u.z * v.x - u.x * v.z;
        r.z = u.x * v.y - u.y * v.x;
        return r;
    endfunction

    // exact sign of the dot product, wide enough for any cross product pair
    function automatic bit dot_below_zero(lvec_t u, lvec_t v);
        logic signed [127:0] ux, uy, uz, vx, vy, vz;
        ux = u.x;
        uy = u.y;
        uz = u.z;
        vx = v.x;
        vy = v.y;
        vz = v.z;
        return (ux * vx + uy * vy + uz * vz) < 0;
    endfunction

    // crossing tests and repaired vertex order for one quad
    function automatic order_result_t predict_order(quad_t q, bit fix);
        lvec_t         a, b, c, d, ab, ac, ad, cd, ca, cb;
        bit            c1, c2;
        order_result_t r;
        a  = widen(q.a);
        b  = widen(q.b);
        c  = widen(q.c);
        d  = widen(q.d);
        ab = span(b, a);
        ac = span(c, a);
        ad = span(d, a);
        cd = span(d, c);
        ca = span(a, c);
        cb = span(b, c);
        c1 = dot_below_zero(cross_of(ad, ab), cross_of(ad, ac)) &&
             dot_below_zero(cross_of(cb, ca), cross_of(cb, cd));
        c2 = dot_below_zero(cross_of(ab, ac), cross_of(ab, ad)) &&
             dot_below_zero(cross_of(cd, ca), cross_of(cd, cb));
        r = NO_CROSS;
        r.cross_first  = c1;
        r.cross_second = c2;
        // first crossing wins when both are set
        if (fix && c1)
        begin
            r.slot2 = qbd_pkg::SRC_D;
            r.slot3 = qbd_pkg::SRC_C;
        end
        else if (fix && c2)
        begin
            r.slot1 = qbd_pkg::SRC_C;
            r.slot2 = qbd_pkg::SRC_B;
        end
        return r;
    endfunction

    // offer one quad after a random gap, record its order once taken
    task automatic send_quad(quad_t q, order_result_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0)
        begin
            quad_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        quad_ch.ax    <= q.a.x;
        quad_ch.ay    <= q.a.y;
        quad_ch.az    <= q.a.z;
        quad_ch.bx    <= q.b.x;
        quad_ch.by    <= q.b.y;
        quad_ch.bz    <= q.b.z;
        quad_ch.cx    <= q.c.x;
        quad_ch.cy    <= q.c.y;
        quad_ch.cz    <= q.c.z;
        quad_ch.dx    <= q.d.x;
        quad_ch.dy    <= q.d.y;
        quad_ch.dz    <= q.d.z;
        quad_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (quad_ch.ready !== 1'b1);
        pending_orders.insert(pending_orders.size(), want);
        @(negedge clk);
    endtask

    // change the correction bit once the pipeline has drained
    task automatic write_fix(bit value);
        quad_ch.valid <= 1'b0;
        while (pending_orders.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we        <= 1'b0;
        correction_on = value;
    endtask

    // result receiver with random stalls
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = take_burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    // compare each taken result with the oldest expected order
    always @(posedge clk)
    begin
        order_result_t got, want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.cross_first  = result_ch.cross_first;
            got.cross_second = result_ch.cross_second;
            got.slot0        = qbd_pkg::vertex_src_t'(result_ch.slot0_source);
            got.slot1        = qbd_pkg::vertex_src_t'(result_ch.slot1_source);
            got.slot2        = qbd_pkg::vertex_src_t'(result_ch.slot2_source);
            got.slot3        = qbd_pkg::vertex_src_t'(result_ch.slot3_source);
            if (pending_orders.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: first=%b second=%b order=%0d %0d %0d %0d",
                             got.cross_first, got.cross_second,
                             got.slot0, got.slot1, got.slot2, got.slot3);
            end
            else
            begin
                want = pending_orders.pop_front();
                if (got.cross_first !== want.cross_first ||
                    got.cross_second !== want.cross_second ||
                    got.slot0 !== want.slot0 || got.slot1 !== want.slot1 ||
                    got.slot2 !== want.slot2 || got.slot3 !== want.slot3)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected first=%b second=%b order=%0d %0d %0d %0d",
                                 want.cross_first, want.cross_second,
                                 want.slot0, want.slot1, want.slot2, want.slot3);
                        $display("          got      first=%b second=%b order=%0d %0d %0d %0d",
                                 got.cross_first, got.cross_second,
                                 got.slot0, got.slot1, got.slot2, got.slot3);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        quad_t   q;
        vertex_t corner [4];
        int      kind, axis, w, scale;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        quad_ch.valid = 1'b0;
        quad_ch.ax    = '0;
        quad_ch.ay    = '0;
        quad_ch.az    = '0;
        quad_ch.bx    = '0;
        quad_ch.by    = '0;
        quad_ch.bz    = '0;
        quad_ch.cx    = '0;
        quad_ch.cy    = '0;
        quad_ch.cz    = '0;
        quad_ch.dx    = '0;
        quad_ch.dy    = '0;
        quad_ch.dz    = '0;

        // directed rows, correction at its reset value first
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(0, 0, 0), vtx(0, 0, 0),
                      vtx(0, 0, 0), vtx(0, 0, 0)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(32767, 32767, 32767),
                      vtx(32767, 32767, 32767), vtx(32767, 32767, 32767),
                      vtx(32767, 32767, 32767)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(-32768, -32768, -32768),
                      vtx(-32768, -32768, -32768), vtx(-32768, -32768, -32768),
                      vtx(-32768, -32768, -32768)}), NO_CROSS});
        // collinear corners: every cross product is zero
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(-32768, -32768, -32768),
                      vtx(32767, 32767, 32767), vtx(-32768, -32768, -32768),
                      vtx(32767, 32767, 32767)}), NO_CROSS});
        // plain square
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, 0, 0),
                      vtx(U, U, 0), vtx(0, U, 0)}), NO_CROSS});
        // flat bowties, one for each test
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, 0, 0),
                      vtx(0, U, 0), vtx(U, U, 0)}), FIRST_KEEP});
        probes.insert(probes.size(), '{1'b0, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, U, 0),
                      vtx(U, 0, 0), vtx(0, U, 0)}), SECOND_KEEP});
        probes.insert(probes.size(), '{1'b0, 1'b0, quad_t'({vtx(-32768, -32768, 32767),
                      vtx(32767, -32768, -32768), vtx(-32768, 32767, 32767),
                      vtx(32767, 32767, -32768)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b0, 1'b0, quad_t'({vtx(0, 0, 0), vtx(U, 0, U),
                      vtx(0, U, -U), vtx(U, U, 0)}), NO_CROSS});
        // correction on
        probes.insert(probes.size(), '{1'b1, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, 0, 0),
                      vtx(0, U, 0), vtx(U, U, 0)}), FIRST_FIX});
        probes.insert(probes.size(), '{1'b1, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, U, 0),
                      vtx(U, 0, 0), vtx(0, U, 0)}), SECOND_FIX});
        probes.insert(probes.size(), '{1'b1, 1'b1, quad_t'({vtx(0, 0, 0), vtx(U, 0, 0),
                      vtx(U, U, 0), vtx(0, U, 0)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b1, quad_t'({vtx(0, 0, 0), vtx(0, 0, 0),
                      vtx(0, 0, 0), vtx(0, 0, 0)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b0, quad_t'({vtx(-32768, -32768, 0),
                      vtx(32767, 32767, 0), vtx(32767, -32768, 0),
                      vtx(-32768, 32767, 0)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b0, quad_t'({vtx(-32768, -32768, 32767),
                      vtx(32767, -32768, -32768), vtx(-32768, 32767, 32767),
                      vtx(32767, 32767, -32768)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b0, quad_t'({vtx(0, 0, 0), vtx(U, 0, U),
                      vtx(0, U, -U), vtx(U, U, 0)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b0, quad_t'({vtx(32767, -32768, 32767),
                      vtx(-32768, 32767, -32768), vtx(-1, 1, 0),
                      vtx(1, -1, -1)}), NO_CROSS});
        probes.insert(probes.size(), '{1'b1, 1'b0, quad_t'({vtx(0, 0, 0), vtx(0, U, 0),
                      vtx(0, 0, U), vtx(0, U, U)}), NO_CROSS});

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (probes[i])
        begin
            if (probes[i].fix != correction_on)
                write_fix(probes[i].fix);
            send_quad(probes[i].q, probes[i].typed ? probes[i].want :
                      predict_order(probes[i].q, correction_on));
        end

        // random quads, correction toggled between phases
        for (int phase = 0; phase < 4; phase++)
        begin
            write_fix(phase[0]);
            for (int n = 0; n < 175; n++)
            begin
                kind  = $urandom_range(0, 9);
                axis  = $urandom_range(0, 2);
                w     = $urandom_range(0, 65535);
                scale = 1 << $urandom_range(0, 11);
                for (int k = 0; k < 4; k++)
                begin
                    case (kind) inside
                        // flat quads on a small grid: many bowties and ties
                        [3:5]:
                        begin
                            case (axis)
                                0: corner[k] = vtx(w,
                                       (int'($urandom_range(0, 16)) - 8) * scale,
                                       (int'($urandom_range(0, 16)) - 8) * scale);
                                1: corner[k] = vtx((int'($urandom_range(0, 16)) - 8) * scale,
                                       w, (int'($urandom_range(0, 16)) - 8) * scale);
                                default: corner[k] = vtx(
                                       (int'($urandom_range(0, 16)) - 8) * scale,
                                       (int'($urandom_range(0, 16)) - 8) * scale, w);
                            endcase
                        end
                        // tiny 3-d quads near degenerate
                        [6:7]:
                            corner[k] = vtx(int'($urandom_range(0, 8)) - 4,
                                            int'($urandom_range(0, 8)) - 4,
                                            int'($urandom_range(0, 8)) - 4);
                        // range corners only
                        8:
                            corner[k] = vtx(EXTREMES[$urandom_range(0, 4)],
                                            EXTREMES[$urandom_range(0, 4)],
                                            EXTREMES[$urandom_range(0, 4)]);
                        // full range
                        default:
                            corner[k] = vtx(int'($urandom()), int'($urandom()),
                                            int'($urandom()));
                    endcase
                end
                // repeated vertex
                if (kind == 9)
                    corner[$urandom_range(0, 3)] = corner[$urandom_range(0, 3)];
                q.a = corner[0];
                q.b = corner[1];
                q.c = corner[2];
                q.d = corner[3];
                send_quad(q, predict_order(q, correction_on));
            end
        end

        // drain
        quad_ch.valid <= 1'b0;
        while (pending_orders.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatch_count == 0 && pending_orders.size() == 0)
            $display("quad_bowtie_detect_fix_test: PASS");
        else
            $display("quad_bowtie_detect_fix_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/qbd_pkg.sv
src/qbd_if.sv
src/quad_bowtie_detect_fix.sv
src/qbd_checker.sv
tb/sv/quad_bowtie_detect_fix_test.sv
